@@ src/kdhc_pkg.sv @@
// shared types, constants and helpers for the key debounce hold classifier
`timescale 1ns / 1ps
`default_nettype none

package kdhc_pkg;

  // field widths
  localparam int unsigned MaskW     = 2;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ShortW    = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 8;
  // threshold compare width holds base plus the widest delay
  localparam int unsigned ThreshW   = CountW + 1;

  // hold count value loaded on a change of the filtered mask
  localparam logic [CountW-1:0] HoldBase = CountW'(20);
  localparam logic [CountW-1:0] CountMax = '1;

  // reset values of the configuration registers
  localparam logic [ShortW-1:0] ShortDelayRst = ShortW'(6);
  localparam logic [LongW-1:0]  LongDelayRst  = LongW'(250);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegShortDelay = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLongDelay  = 1'b1;

  // key codes
  localparam logic [CodeW-1:0] CodeNone = 5'd0;
  localparam logic [CodeW-1:0] CodeOne  = 5'd1;
  localparam logic [CodeW-1:0] CodeTwo  = 5'd2;
  localparam logic [CodeW-1:0] CodeBoth = 5'd31;

  // one result item
  typedef struct packed {
    logic             long_hold;
    logic [CodeW-1:0] key_number;
  } result_t;

  // pressed mask to key code
  function automatic logic [CodeW-1:0] mask_to_code(input logic [MaskW-1:0] mask);
    logic [CodeW-1:0] code;
    unique case (mask)
      2'b00:   code = CodeNone;
      2'b01:   code = CodeOne;
      2'b10:   code = CodeTwo;
      default: code = CodeBoth;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ src/kdhc_filter.sv @@
// sample history and bitwise 2-of-3 majority filter of the pressed mask
`timescale 1ns / 1ps
`default_nettype none

module kdhc_filter (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        step_i,
  input  wire                        key_one_level_i,
  input  wire                        key_two_level_i,
  output logic [kdhc_pkg::MaskW-1:0] filt_o
);

  logic [kdhc_pkg::MaskW-1:0] raw;
  logic [kdhc_pkg::MaskW-1:0] hist0_q, hist1_q;

  // active-low levels to pressed mask
  assign raw = {~key_two_level_i, ~key_one_level_i};

  // majority over current and two previous masks
  assign filt_o = (raw & hist0_q) | (hist0_q & hist1_q) | (hist1_q & raw);

  // history shift on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q <= '0;
      hist1_q <= '0;
    end else if (step_i) begin
      hist1_q <= hist0_q;
      hist0_q <= raw;
    end
  end

endmodule

`default_nettype wire

@@ src/kdhc_hold.sv @@
// hold counter, code latch and one-shot report of the latched code
`timescale 1ns / 1ps
`default_nettype none

module kdhc_hold (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         step_i,
  input  wire  [kdhc_pkg::MaskW-1:0]  filt_i,
  input  wire  [kdhc_pkg::ShortW-1:0] short_delay_i,
  input  wire  [kdhc_pkg::LongW-1:0]  long_delay_i,
  output logic                        res_valid_o,
  output kdhc_pkg::result_t           res_o
);

  logic [kdhc_pkg::MaskW-1:0]   stable_q, stable_d;
  logic [kdhc_pkg::CountW-1:0]  count_q, count_d, count_inc;
  logic [kdhc_pkg::CodeW-1:0]   code_q, code_d;
  logic                         long_q, long_d;
  logic                         reported_q, reported_d;
  logic [kdhc_pkg::ThreshW-1:0] short_at, long_at, count_ext;

  // thresholds relative to zero count
  assign short_at  = kdhc_pkg::ThreshW'(kdhc_pkg::HoldBase)
                   + kdhc_pkg::ThreshW'(short_delay_i);
  assign long_at   = kdhc_pkg::ThreshW'(kdhc_pkg::HoldBase)
                   + kdhc_pkg::ThreshW'(long_delay_i);
  // saturating increment
  assign count_inc = (count_q == kdhc_pkg::CountMax) ? count_q
                                                     : count_q + 1'b1;
  assign count_ext = kdhc_pkg::ThreshW'(count_inc);

  // next state for one tick
  always_comb begin
    stable_d   = stable_q;
    count_d    = count_q;
    code_d     = code_q;
    long_d     = long_q;
    reported_d = reported_q;
    if (filt_i != stable_q) begin
      stable_d = filt_i;
      count_d  = kdhc_pkg::HoldBase;
    end else begin
      count_d = count_inc;
      priority if (count_ext == short_at) begin
        code_d     = kdhc_pkg::mask_to_code(stable_q);
        long_d     = 1'b0;
        reported_d = 1'b0;
      end else if (count_ext == long_at) begin
        long_d     = 1'b1;
        reported_d = 1'b0;
      end else begin
        // between thresholds, latch stays as it is
      end
    end
  end

  // report when the latched code is still unreported
  assign res_valid_o      = step_i & ~reported_d;
  assign res_o.key_number = code_d;
  assign res_o.long_hold  = long_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= '0;
      count_q    <= '0;
      code_q     <= kdhc_pkg::CodeNone;
      long_q     <= 1'b0;
      reported_q <= 1'b0;
    end else if (step_i) begin
      stable_q   <= stable_d;
      count_q    <= count_d;
      code_q     <= code_d;
      long_q     <= long_d;
      reported_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ src/kdhc_out_buf.sv @@
// two-entry output buffer: result register plus skid register
`timescale 1ns / 1ps
`default_nettype none

module kdhc_out_buf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  kdhc_pkg::result_t  push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output kdhc_pkg::result_t  out_data_o
);

  logic              out_valid_q, skid_valid_q;
  kdhc_pkg::result_t out_q, skid_q;
  logic              pop;

  assign pop         = out_valid_q & out_ready_i;
  assign space_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= skid_valid_q & push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= push_data_i;
        end
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/key_debounce_hold_classifier.sv @@
// top level of the two-key debounce and hold classifier
`timescale 1ns / 1ps
`default_nettype none

// Takes one scan tick per clock cycle. Each request carries two active-low
// key levels; a 2-of-3 majority filter and a saturating hold counter decide
// when a key code (0 none, 1, 2, 31 both) and later a long-hold flag are
// latched, and each latch is reported once. Each report is registered in a
// two-entry output buffer before it reaches the master side, so
// s_axis_tready drops only when both entries hold results that the sink has
// not taken; otherwise a tick is taken every cycle. Just after reset one
// report of code 0 follows the first tick. Delay registers must be written
// through cfg_we_i while no tick is in flight; the block does not enforce it.

module key_debounce_hold_classifier (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration writes
  input  wire                              cfg_we_i,
  input  wire  [kdhc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [kdhc_pkg::CfgDataW-1:0]    cfg_data_i,
  // scan ticks
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [kdhc_pkg::InDataW-1:0]     s_axis_tdata,  // [0] key_one_level, [1] key_two_level
  // key reports
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [kdhc_pkg::OutDataW-1:0]    m_axis_tdata   // [4:0] key_number, [5] long_hold
);

  logic [kdhc_pkg::ShortW-1:0] short_delay_q;
  logic [kdhc_pkg::LongW-1:0]  long_delay_q;
  logic                        step;
  logic [kdhc_pkg::MaskW-1:0]  filt;
  logic                        res_valid;
  kdhc_pkg::result_t           res, out_res;
  logic                        space;

  // delay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_delay_q <= kdhc_pkg::ShortDelayRst;
      long_delay_q  <= kdhc_pkg::LongDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdhc_pkg::RegShortDelay: short_delay_q <= cfg_data_i[kdhc_pkg::ShortW-1:0];
        kdhc_pkg::RegLongDelay:  long_delay_q  <= cfg_data_i[kdhc_pkg::LongW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = space;
  assign step          = s_axis_tvalid & space;

  kdhc_filter u_filter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .key_one_level_i (s_axis_tdata[0]),
    .key_two_level_i (s_axis_tdata[1]),
    .filt_o          (filt)
  );

  kdhc_hold u_hold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .filt_i        (filt),
    .short_delay_i (short_delay_q),
    .long_delay_i  (long_delay_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  kdhc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // pack result, zero padding above the fields
  assign m_axis_tdata = {2'b00, out_res.long_hold, out_res.key_number};

endmodule

`default_nettype wire

@@ src/kdhc_checker.sv @@
// port-level checks on the key debounce hold classifier
`timescale 1ns / 1ps
`default_nettype none

module kdhc_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [kdhc_pkg::OutDataW-1:0]  m_axis_tdata
);

  // a stalled report holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("report changed while stalled");

  // backpressure only with a report waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // only defined key codes are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:0] == kdhc_pkg::CodeNone ||
                       m_axis_tdata[4:0] == kdhc_pkg::CodeOne  ||
                       m_axis_tdata[4:0] == kdhc_pkg::CodeTwo  ||
                       m_axis_tdata[4:0] == kdhc_pkg::CodeBoth))
    else $error("undefined key code reported");

  // padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
    else $error("nonzero padding in report");

endmodule

bind key_debounce_hold_classifier kdhc_checker u_kdhc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
